>>> hdl/ljc_pkg.sv
// Package for the LJ 12-6 plus Coulomb pair force block.
// Holds the sequencer state type and the micro-op program of the shared multiplier.
// No dependencies.
package ljc_pkg;

	localparam int unsigned InvSteps = 49;   // quotient bits of 2^48 / dist_sq
	localparam int unsigned RootSteps = 32;  // result bits of sqrt(dist_sq * 2^32)
	localparam int unsigned CdivSteps = 88;  // bits of |q| * 2^24
	localparam int unsigned ProgLen = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INV,
		ST_ROOT,
		ST_CDIV,
		ST_MICRO,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_ADD,
		OP_SUB
	} op_kind_t;

	typedef enum logic [3:0] {
		R_INV,
		R_INV6,
		R_CA,
		R_CB,
		R_A12,
		R_B6,
		R_P,
		R_T,
		R_COUL,
		R_E,
		R_TOT,
		R_CACC,
		R_K12,
		R_K6,
		R_FORCE
	} reg_sel_t;

	typedef struct packed {
		op_kind_t kind;
		reg_sel_t src_a;
		reg_sel_t src_b;
		reg_sel_t dst;
	} micro_op_t;

	function automatic micro_op_t prog(input logic [3:0] step);
		micro_op_t m;
		m = '{OP_MUL, R_INV, R_INV, R_P};
		unique case (step)
			4'd0:  m = '{OP_MUL, R_INV, R_INV, R_P};
			4'd1:  m = '{OP_MUL, R_P, R_INV, R_INV6};
			4'd2:  m = '{OP_MUL, R_CA, R_K12, R_A12};
			4'd3:  m = '{OP_MUL, R_CB, R_K6, R_B6};
			4'd4:  m = '{OP_MUL, R_A12, R_INV6, R_P};
			4'd5:  m = '{OP_SUB, R_B6, R_P, R_T};
			4'd6:  m = '{OP_MUL, R_T, R_INV6, R_T};
			4'd7:  m = '{OP_MUL, R_T, R_INV, R_T};
			4'd8:  m = '{OP_MUL, R_COUL, R_INV, R_P};
			4'd9:  m = '{OP_SUB, R_T, R_P, R_FORCE};
			4'd10: m = '{OP_MUL, R_CA, R_INV6, R_P};
			4'd11: m = '{OP_SUB, R_P, R_CB, R_E};
			4'd12: m = '{OP_MUL, R_E, R_INV6, R_E};
			4'd13: m = '{OP_ADD, R_E, R_COUL, R_E};
			4'd14: m = '{OP_ADD, R_TOT, R_E, R_TOT};
			4'd15: m = '{OP_ADD, R_CACC, R_COUL, R_CACC};
			default: m = '{OP_MUL, R_INV, R_INV, R_P};
		endcase
		return m;
	endfunction

endpackage

>>> hdl/lj_coulomb_pair_force_top.sv
// LJ 12-6 plus Coulomb pair force, top level.
// Uses ljc_pkg for the state type and the micro-op program.
//
// Usage:
//   s_* channel takes one atom pair per request, m_* channel returns one result.
//   s_tready is high only while the sequencer is idle; a pair is accepted when
//   s_tvalid and s_tready are both high.
//   From accept to m_tvalid, a nonzero distance passes through a restoring
//   division for 1/r^2 (49 quotient bits), a bit-serial square root (32 bits),
//   a restoring division for q/r (88 bits plus one to saturate), then
//   16 micro-ops on one 32x32 multiplier (Q32.32 products and add/sub steps),
//   then a load of the output register. A zero distance goes straight to the
//   output load. A new pair is taken only once the previous one has finished
//   and the sequencer is back in idle.
//   The result sits in an output register; the next pair is taken while it
//   waits. If the receiver stalls, the sequencer holds the next finished
//   result until the output register is free.
//   start_group clears both energy sums when the pair is accepted.
//   Reset (arst_n low) clears the sums, the sequencer and m_tvalid.
module lj_coulomb_pair_force_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// dist_sq[31:0], coef_repel[95:32], coef_attract[159:96], charge_product[223:160],
	// site_tag[229:224], partner_tag[232:230], zero pad [239:233]
	input  logic [239:0] s_tdata,
	// start_group[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_factor[63:0], energy_total[127:64], energy_coulomb[191:128],
	// site_tag_out[197:192], partner_tag_out[200:198], zero pad [207:201]
	output logic [207:0] m_tdata,
	// range_error[0]
	output logic         m_tuser
);

	localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

	function automatic logic [63:0] magn(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

	// returns {flag, value}
	function automatic logic [64:0] pack(input logic neg, input logic [63:0] m,
			input logic ovf);
		if (!neg) begin
			if (ovf || m > SMAX) return {1'b1, SMAX};
			return {1'b0, m};
		end
		if (ovf || m > SMIN) return {1'b1, SMIN};
		return {1'b0, 64'd0 - m};
	endfunction

	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b,
			input logic sub);
		logic [63:0] s;
		logic        ovf;
		s = sub ? (a - b) : (a + b);
		ovf = ((sub ? (a[63] != b[63]) : (a[63] == b[63]))) && (s[63] != a[63]);
		if (ovf) return {1'b1, a[63] ? SMIN : SMAX};
		return {1'b0, s};
	endfunction

	ljc_pkg::state_t state_q, state_d;

	logic [31:0]  dsq_q;
	logic [63:0]  ca_q, cb_q, cq_q;
	logic [5:0]   site_q;
	logic [2:0]   partner_q;
	logic [6:0]   cnt_q;
	logic [3:0]   step_q;
	logic [2:0]   mph_q;
	logic         err_q;

	logic [32:0]  rem_q;
	logic [63:0]  quo_q;
	logic [87:0]  dvd_q;
	logic         dovf_q;
	logic [63:0]  sx_q, sres_q, sbit_q;

	logic [63:0]  inv_q, inv6_q, coul_q, a12_q, b6_q, p_q, t_q, e_q, force_q;
	logic [63:0]  tot_q, cacc_q;

	logic [63:0]  ma_q, mb_q;
	logic         mneg_q;
	logic [127:0] acc_q;

	logic         out_valid_q, out_err_q;
	logic [63:0]  out_force_q, out_tot_q, out_cacc_q;
	logic [5:0]   out_site_q;
	logic [2:0]   out_partner_q;

	logic              accept;
	ljc_pkg::micro_op_t uop;
	logic [63:0]       op_a, op_b;
	logic [1:0]        pk;
	logic [31:0]       mx, my;
	logic [63:0]       pp;
	logic [6:0]        shamt;
	logic [64:0]       mul_res, as_res, step_res, cdiv_res;
	logic [32:0]       inv_rem, cd_rem;
	logic [63:0]       sq_sum;
	logic              step_done, last_step, out_free;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ljc_pkg::ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	assign uop = ljc_pkg::prog(step_q);

	function automatic logic [63:0] pick(input ljc_pkg::reg_sel_t s,
			input logic [63:0] inv, input logic [63:0] inv6, input logic [63:0] ca,
			input logic [63:0] cb, input logic [63:0] a12, input logic [63:0] b6,
			input logic [63:0] p, input logic [63:0] t, input logic [63:0] coul,
			input logic [63:0] e, input logic [63:0] tot, input logic [63:0] cacc);
		logic [63:0] v;
		v = '0;
		unique case (s)
			ljc_pkg::R_INV:   v = inv;
			ljc_pkg::R_INV6:  v = inv6;
			ljc_pkg::R_CA:    v = ca;
			ljc_pkg::R_CB:    v = cb;
			ljc_pkg::R_A12:   v = a12;
			ljc_pkg::R_B6:    v = b6;
			ljc_pkg::R_P:     v = p;
			ljc_pkg::R_T:     v = t;
			ljc_pkg::R_COUL:  v = coul;
			ljc_pkg::R_E:     v = e;
			ljc_pkg::R_TOT:   v = tot;
			ljc_pkg::R_CACC:  v = cacc;
			ljc_pkg::R_K12:   v = 64'd12 << 32;
			ljc_pkg::R_K6:    v = 64'd6 << 32;
			default:          v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		op_a = pick(uop.src_a, inv_q, inv6_q, ca_q, cb_q, a12_q, b6_q, p_q, t_q,
			coul_q, e_q, tot_q, cacc_q);
		op_b = pick(uop.src_b, inv_q, inv6_q, ca_q, cb_q, a12_q, b6_q, p_q, t_q,
			coul_q, e_q, tot_q, cacc_q);
		// one 32x32 partial product per phase, phases 1..4
		pk = 2'(mph_q - 3'd1);
		mx = pk[0] ? ma_q[63:32] : ma_q[31:0];
		my = pk[1] ? mb_q[63:32] : mb_q[31:0];
		pp = {32'd0, mx} * {32'd0, my};
		shamt = {pk[0] & pk[1], pk[0] ^ pk[1], 5'd0};
		mul_res = pack(mneg_q, acc_q[95:32], acc_q[127:96] != 32'd0);
		as_res = sat_add(op_a, op_b, uop.kind == ljc_pkg::OP_SUB);
		step_res = (uop.kind == ljc_pkg::OP_MUL) ? mul_res : as_res;
		step_done = (uop.kind == ljc_pkg::OP_MUL) ? (mph_q == 3'd5) : 1'b1;
		last_step = (step_q == 4'(ljc_pkg::ProgLen - 1));
		inv_rem = {rem_q[31:0], (cnt_q == 7'd0)};
		cd_rem = {rem_q[31:0], dvd_q[87]};
		sq_sum = sres_q + sbit_q;
		cdiv_res = pack(cq_q[63], quo_q, dovf_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ljc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (s_tdata[31:0] == 32'd0) ? ljc_pkg::ST_FINISH
						: ljc_pkg::ST_INV;
				end
			end
			ljc_pkg::ST_INV: begin
				if (cnt_q == 7'(ljc_pkg::InvSteps - 1)) state_d = ljc_pkg::ST_ROOT;
			end
			ljc_pkg::ST_ROOT: begin
				if (cnt_q == 7'(ljc_pkg::RootSteps - 1)) state_d = ljc_pkg::ST_CDIV;
			end
			ljc_pkg::ST_CDIV: begin
				if (cnt_q == 7'(ljc_pkg::CdivSteps)) state_d = ljc_pkg::ST_MICRO;
			end
			ljc_pkg::ST_MICRO: begin
				if (step_done && last_step) state_d = ljc_pkg::ST_FINISH;
			end
			ljc_pkg::ST_FINISH: begin
				if (out_free) state_d = ljc_pkg::ST_IDLE;
			end
			default: state_d = ljc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ljc_pkg::ST_IDLE;
			cnt_q <= '0;
			step_q <= '0;
			mph_q <= '0;
			err_q <= 1'b0;
			tot_q <= '0;
			cacc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ljc_pkg::ST_FINISH && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ljc_pkg::ST_IDLE: begin
					cnt_q <= '0;
					step_q <= '0;
					mph_q <= '0;
					if (accept) begin
						err_q <= (s_tdata[31:0] == 32'd0);
						if (s_tuser) begin
							tot_q <= '0;
							cacc_q <= '0;
						end
					end
				end
				ljc_pkg::ST_INV, ljc_pkg::ST_ROOT: begin
					cnt_q <= (state_d == state_q) ? cnt_q + 7'd1 : 7'd0;
				end
				ljc_pkg::ST_CDIV: begin
					cnt_q <= cnt_q + 7'd1;
				end
				ljc_pkg::ST_MICRO: begin
					if (uop.kind == ljc_pkg::OP_MUL && !step_done) mph_q <= mph_q + 3'd1;
					if (step_done) begin
						mph_q <= '0;
						step_q <= step_q + 4'd1;
						err_q <= err_q | step_res[64];
						if (uop.dst == ljc_pkg::R_TOT) tot_q <= step_res[63:0];
						if (uop.dst == ljc_pkg::R_CACC) cacc_q <= step_res[63:0];
					end
				end
				default: ;
			endcase
			// Coulomb divide wraps up on the extra count
			if (state_q == ljc_pkg::ST_CDIV && cnt_q == 7'(ljc_pkg::CdivSteps)) begin
				err_q <= err_q | cdiv_res[64];
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ljc_pkg::ST_IDLE: begin
				if (accept) begin
					dsq_q <= s_tdata[31:0];
					ca_q <= s_tdata[95:32];
					cb_q <= s_tdata[159:96];
					cq_q <= s_tdata[223:160];
					site_q <= s_tdata[229:224];
					partner_q <= s_tdata[232:230];
					force_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			ljc_pkg::ST_INV: begin
				// 2^48 / dsq: the only set dividend bit enters first
				if (inv_rem >= {1'b0, dsq_q}) begin
					rem_q <= inv_rem - {1'b0, dsq_q};
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= inv_rem;
					quo_q <= {quo_q[62:0], 1'b0};
				end
				if (state_d != state_q) begin
					inv_q <= {quo_q[62:0], inv_rem >= {1'b0, dsq_q}};
					sx_q <= {dsq_q, 32'd0};
					sres_q <= '0;
					sbit_q <= 64'd1 << 62;
				end
			end
			ljc_pkg::ST_ROOT: begin
				if (sx_q >= sq_sum) begin
					sx_q <= sx_q - sq_sum;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
				rem_q <= '0;
				quo_q <= '0;
				dovf_q <= 1'b0;
				dvd_q <= {magn(cq_q), 24'd0};
			end
			ljc_pkg::ST_CDIV: begin
				if (cnt_q != 7'(ljc_pkg::CdivSteps)) begin
					dvd_q <= {dvd_q[86:0], 1'b0};
					if (cd_rem >= {1'b0, sres_q[31:0]}) begin
						rem_q <= cd_rem - {1'b0, sres_q[31:0]};
						quo_q <= {quo_q[62:0], 1'b1};
						if (cnt_q < 7'd24) dovf_q <= 1'b1;
					end else begin
						rem_q <= cd_rem;
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end else begin
					coul_q <= cdiv_res[63:0];
				end
			end
			ljc_pkg::ST_MICRO: begin
				if (uop.kind == ljc_pkg::OP_MUL) begin
					if (mph_q == 3'd0) begin
						ma_q <= magn(op_a);
						mb_q <= magn(op_b);
						mneg_q <= op_a[63] ^ op_b[63];
						acc_q <= '0;
					end else if (mph_q != 3'd5) begin
						acc_q <= acc_q + ({64'd0, pp} << shamt);
					end
				end
				if (step_done) begin
					unique case (uop.dst)
						ljc_pkg::R_INV6:  inv6_q <= step_res[63:0];
						ljc_pkg::R_A12:   a12_q <= step_res[63:0];
						ljc_pkg::R_B6:    b6_q <= step_res[63:0];
						ljc_pkg::R_P:     p_q <= step_res[63:0];
						ljc_pkg::R_T:     t_q <= step_res[63:0];
						ljc_pkg::R_E:     e_q <= step_res[63:0];
						ljc_pkg::R_FORCE: force_q <= step_res[63:0];
						default: ;
					endcase
				end
			end
			ljc_pkg::ST_FINISH: begin
				if (out_free) begin
					out_force_q <= force_q;
					out_tot_q <= tot_q;
					out_cacc_q <= cacc_q;
					out_err_q <= err_q;
					out_site_q <= site_q;
					out_partner_q <= partner_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'd0, out_partner_q, out_site_q, out_cacc_q, out_tot_q, out_force_q};
	assign m_tuser = out_err_q;

endmodule
